// File: design/tpcs_pkg.sv
// shared widths, codes and pipeline control type for the current sense block
package tpcs_pkg;

  // field widths
  localparam int unsigned NPH     = 3;
  localparam int unsigned RAW_W   = 12;
  localparam int unsigned SUM_W   = 19;
  localparam int unsigned OFS_W   = 20;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned CUR_W   = 24;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AMPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV  = 1'd1;

  // configuration reset values
  localparam logic [SCALE_W-1:0] AMPS_RESET = 24'd27040;
  localparam logic [NPH-1:0]     INV_RESET  = 3'd3;

  // item kinds carried on tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_RECAL  = 1'b1;

  // per-stage load enables of the sample pipeline
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ldo;
  } pipe_ctl_t;

endpackage

// File: design/tpcs_ofs_div.sv
// offset average: rounded divide of a calibration sum by the sample count
module tpcs_ofs_div #(
  parameter int unsigned CAL_SAMPLES = 100
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [tpcs_pkg::SUM_W-1:0]  sum,
  output logic [tpcs_pkg::OFS_W-1:0]  quot
);

  localparam int unsigned N_W     = tpcs_pkg::SUM_W + tpcs_pkg::FRAC_W;
  localparam int unsigned RECIP_W = N_W + 1;
  localparam int unsigned PROD_W  = N_W + RECIP_W;
  localparam int unsigned QC_W    = N_W + tpcs_pkg::CNT_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << N_W) / CAL_SAMPLES);
  localparam logic [N_W-1:0] HALF = N_W'(CAL_SAMPLES / 2);
  localparam logic [tpcs_pkg::CNT_W-1:0] DIV_C = tpcs_pkg::CNT_W'(CAL_SAMPLES);

  logic [N_W-1:0]    numer;
  logic [N_W-1:0]    n_r;
  logic [PROD_W-1:0] prod_r;
  logic [N_W-1:0]    q0;
  logic [QC_W-1:0]   qc;
  logic [QC_W-1:0]   rem;
  logic              corr;

  // numerator with half the divisor added for round to nearest
  assign numer = {sum, tpcs_pkg::FRAC_W'(0)} + HALF;

  // reciprocal multiply, estimate is exact or one low
  always_ff @(posedge clk) begin
    if (load) begin
      n_r    <= numer;
      prod_r <= PROD_W'(numer) * PROD_W'(RECIP);
    end
  end

  // remainder check and correction
  assign q0   = prod_r[N_W +: N_W];
  assign qc   = QC_W'(q0) * QC_W'(DIV_C);
  assign rem  = QC_W'(n_r) - qc;
  assign corr = (rem >= QC_W'(DIV_C));
  assign quot = q0[tpcs_pkg::OFS_W-1:0] + tpcs_pkg::OFS_W'(corr);

endmodule

// File: design/tpcs_phase.sv
// one phase of the sample pipeline: offset subtract, scale, round, sign, saturate
module tpcs_phase (
  input  logic                              clk,
  input  tpcs_pkg::pipe_ctl_t               ctl,
  input  logic [tpcs_pkg::RAW_W-1:0]        raw,
  input  logic [tpcs_pkg::OFS_W-1:0]        ofs,
  input  logic [tpcs_pkg::SCALE_W-1:0]      scale,
  input  logic                              inv,
  output logic signed [tpcs_pkg::CUR_W-1:0] current,
  output logic                              clip
);

  localparam int unsigned DIFF_W = tpcs_pkg::OFS_W + 1;
  localparam int unsigned PROD_W = tpcs_pkg::OFS_W + tpcs_pkg::SCALE_W;
  localparam int unsigned RND_SH = 16;
  localparam int unsigned MAG_W  = PROD_W - RND_SH;
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (RND_SH - 1);
  localparam logic [MAG_W-1:0]  POS_LIM  = (MAG_W'(1) << (tpcs_pkg::CUR_W - 1)) - MAG_W'(1);
  localparam logic [MAG_W-1:0]  NEG_LIM  = MAG_W'(1) << (tpcs_pkg::CUR_W - 1);
  localparam logic [tpcs_pkg::CUR_W-1:0] CUR_MAX = POS_LIM[tpcs_pkg::CUR_W-1:0];
  localparam logic [tpcs_pkg::CUR_W-1:0] CUR_MIN = NEG_LIM[tpcs_pkg::CUR_W-1:0];

  logic [tpcs_pkg::RAW_W-1:0] raw1;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          diff_abs;
  logic                       neg2;
  logic [tpcs_pkg::OFS_W-1:0] mag2;
  logic                       sgn3;
  logic [PROD_W-1:0]          prod3;
  logic [PROD_W-1:0]          rnd;
  logic [MAG_W-1:0]           mag_r;
  logic [MAG_W-1:0]           mag_neg;
  logic [tpcs_pkg::CUR_W-1:0] cur_next;
  logic                       clip_next;

  // input stage
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      raw1 <= raw;
    end
  end

  // signed difference in counts with 8 fraction bits, split to sign and magnitude
  assign diff     = $signed({1'b0, raw1, tpcs_pkg::FRAC_W'(0)}) - $signed({1'b0, ofs});
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      neg2 <= diff[DIFF_W-1];
      mag2 <= diff_abs[tpcs_pkg::OFS_W-1:0];
    end
  end

  // scale by amps per count
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      sgn3  <= neg2 ^ inv;
      prod3 <= PROD_W'(mag2) * PROD_W'(scale);
    end
  end

  // round half away from zero, apply sign, clamp
  assign rnd     = prod3 + RND_HALF;
  assign mag_r   = rnd[PROD_W-1:RND_SH];
  assign mag_neg = ~mag_r + MAG_W'(1);

  always_comb begin
    clip_next = 1'b0;
    if (!sgn3) begin
      if (mag_r > POS_LIM) begin
        cur_next  = CUR_MAX;
        clip_next = 1'b1;
      end else begin
        cur_next = mag_r[tpcs_pkg::CUR_W-1:0];
      end
    end else begin
      if (mag_r > NEG_LIM) begin
        cur_next  = CUR_MIN;
        clip_next = 1'b1;
      end else begin
        cur_next = mag_neg[tpcs_pkg::CUR_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.ldo) begin
      current <= $signed(cur_next);
      clip    <= clip_next;
    end
  end

endmodule

// File: design/three_phase_current_sense_unit.sv
// three-phase current sense: offset calibration and scaled, saturated phase currents
// latency: four register stages; a sample word's result word is presented on m_tdata once it
//   has passed raw1, neg2/mag2, prod3 and current, later only under output stall
// throughput: one word per cycle unless the output stalls; the cycle after the last
//   calibration word takes no word while the two-stage reciprocal divider forms the offsets
// reset (synchronous, active high): calibration active, count and sums zero,
//   offsets zero, amps_per_count 27040, invert_mask 3, pipeline empty
module three_phase_current_sense_unit #(
  parameter int unsigned CAL_SAMPLES = 100
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: raw_a[11:0], raw_b[23:12], raw_c[35:24], zero fill
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [39:0]                        s_tdata,
  // s_tuser: action
  input  logic                               s_tuser,
  // m_tdata: amps_a[23:0], amps_b[47:24], amps_c[71:48], clipped[74:72]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [79:0]                        m_tdata,
  input  logic                               cfg_we,
  input  logic [tpcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpcs_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam logic [tpcs_pkg::CNT_W-1:0] CAL_CNT = tpcs_pkg::CNT_W'(CAL_SAMPLES);

  logic [tpcs_pkg::SCALE_W-1:0] amps_per_count;
  logic [tpcs_pkg::NPH-1:0]     invert_mask;
  logic                         calibrating;
  logic [tpcs_pkg::CNT_W-1:0]   samples_taken;
  logic [tpcs_pkg::CNT_W-1:0]   samples_next;
  logic [tpcs_pkg::SUM_W-1:0]   offset_sum   [tpcs_pkg::NPH];
  logic [tpcs_pkg::OFS_W-1:0]   offset_value [tpcs_pkg::NPH];
  logic [tpcs_pkg::OFS_W-1:0]   quot         [tpcs_pkg::NPH];
  logic [tpcs_pkg::RAW_W-1:0]   raw_in       [tpcs_pkg::NPH];
  logic signed [tpcs_pkg::CUR_W-1:0] cur     [tpcs_pkg::NPH];
  logic [tpcs_pkg::NPH-1:0]     clip;
  logic                         div_start;
  logic                         ofs_load;
  logic                         v1, v2, v3;
  logic                         accept;
  logic                         cal_end;
  tpcs_pkg::pipe_ctl_t          ctl;

  assign raw_in[0] = s_tdata[11:0];
  assign raw_in[1] = s_tdata[23:12];
  assign raw_in[2] = s_tdata[35:24];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      amps_per_count <= tpcs_pkg::AMPS_RESET;
      invert_mask    <= tpcs_pkg::INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpcs_pkg::REG_AMPS: amps_per_count <= cfg_wdata;
        tpcs_pkg::REG_INV:  invert_mask    <= cfg_wdata[tpcs_pkg::NPH-1:0];
      endcase
    end
  end

  // pipeline flow control, each stage loads when empty or draining
  always_comb begin
    ctl.ldo = !m_tvalid || m_tready;
    ctl.ld3 = !v3 || ctl.ldo;
    ctl.ld2 = !v2 || ctl.ld3;
    ctl.ld1 = !v1 || ctl.ld2;
  end

  assign s_tready     = ctl.ld1 && !div_start;
  assign accept       = s_tvalid && s_tready;
  assign samples_next = samples_taken + tpcs_pkg::CNT_W'(1);
  assign cal_end      = (samples_next >= CAL_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctl.ld1) v1 <= accept && (s_tuser == tpcs_pkg::ACT_SAMPLE) && !calibrating;
      if (ctl.ld2) v2 <= v1;
      if (ctl.ld3) v3 <= v2;
      if (ctl.ldo) m_tvalid <= v3;
    end
  end

  // calibration counter and sums, offsets loaded from the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating   <= 1'b1;
      samples_taken <= '0;
      div_start     <= 1'b0;
      ofs_load      <= 1'b0;
      for (int i = 0; i < tpcs_pkg::NPH; i++) begin
        offset_sum[i]   <= '0;
        offset_value[i] <= '0;
      end
    end else begin
      div_start <= 1'b0;
      ofs_load  <= div_start;
      if (ofs_load) begin
        for (int i = 0; i < tpcs_pkg::NPH; i++) begin
          offset_value[i] <= quot[i];
        end
      end
      if (accept) begin
        if (s_tuser == tpcs_pkg::ACT_RECAL) begin
          calibrating   <= 1'b1;
          samples_taken <= '0;
          for (int i = 0; i < tpcs_pkg::NPH; i++) begin
            offset_sum[i] <= '0;
          end
        end else if (calibrating) begin
          samples_taken <= samples_next;
          for (int i = 0; i < tpcs_pkg::NPH; i++) begin
            offset_sum[i] <= offset_sum[i] + tpcs_pkg::SUM_W'(raw_in[i]);
          end
          if (cal_end) begin
            calibrating <= 1'b0;
            div_start   <= 1'b1;
          end
        end
      end
    end
  end

  // per-phase divider and datapath
  for (genvar p = 0; p < tpcs_pkg::NPH; p++) begin : g_phase
    tpcs_ofs_div #(
      .CAL_SAMPLES(CAL_SAMPLES)
    ) u_div (
      .clk  (clk),
      .load (div_start),
      .sum  (offset_sum[p]),
      .quot (quot[p])
    );

    tpcs_phase u_phase (
      .clk     (clk),
      .ctl     (ctl),
      .raw     (raw_in[p]),
      .ofs     (offset_value[p]),
      .scale   (amps_per_count),
      .inv     (invert_mask[p]),
      .current (cur[p]),
      .clip    (clip[p])
    );
  end

  assign m_tdata = {5'd0, clip, cur[2], cur[1], cur[0]};

`ifndef SYNTH
  // the count stays below the target while calibration runs
  a_cal_count: assert property (@(posedge clk) disable iff (rst)
    calibrating |-> (samples_taken < CAL_CNT))
    else $error("calibration count reached target while calibrating");

  // outside calibration the count sits at the target
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    !calibrating |-> (samples_taken == CAL_CNT))
    else $error("calibration finished with wrong count");

  // offsets are only rewritten after a calibration has finished
  a_ofs_load: assert property (@(posedge clk) disable iff (rst)
    ofs_load |-> !calibrating && $past(div_start))
    else $error("offset load outside calibration end");

  // a sample word outside calibration enters the pipeline
  a_enter: assert property (@(posedge clk) disable iff (rst)
    accept && (s_tuser == tpcs_pkg::ACT_SAMPLE) && !calibrating |=> v1)
    else $error("sample word lost at pipeline entry");
`endif

endmodule
